// ----- design/ifwd_pkg.sv -----
package ifwd_pkg;

	localparam int WINDOW_DEF      = 50;
	localparam int SAMPLE_BITS_DEF = 12;

	// operation codes of an input item
	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_EVAL  = 2'd1;
	localparam logic [1:0] OP_RESET = 2'd2;

	// detector states
	localparam logic [1:0] AL_IDLE = 2'd0;
	localparam logic [1:0] AL_WARN = 2'd1;
	localparam logic [1:0] AL_FIRE = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_POWER_THR   = 3'd0;
	localparam logic [2:0] REG_RATIO_A_THR = 3'd1;
	localparam logic [2:0] REG_RATIO_B_THR = 3'd2;
	localparam logic [2:0] REG_FREQ_LOW    = 3'd3;
	localparam logic [2:0] REG_FREQ_HIGH   = 3'd4;
	localparam logic [2:0] REG_CONFIRM     = 3'd5;

	// what the shared divider is working on
	localparam logic [2:0] DS_MEAN    = 3'd0;
	localparam logic [2:0] DS_POWER   = 3'd1;
	localparam logic [2:0] DS_RATIO_A = 3'd2;
	localparam logic [2:0] DS_RATIO_B = 3'd3;
	localparam logic [2:0] DS_TENTHS  = 3'd4;

	localparam logic [1:0] CH_LAST = 2'd2;

	localparam logic [31:0] RATIO_ZERO_DEN = 32'd9999;
	localparam logic [15:0] FREQ_HIGH_RST  = 16'hffff;

	// q15 biquad coefficients
	localparam int COEF_B0 = 6770;
	localparam int COEF_B1 = 13543;
	localparam int COEF_A1 = 12104;
	localparam int COEF_A2 = 6416;

	typedef struct packed {
		logic [1:0]  op;
		logic [11:0] sample_main;
		logic [11:0] sample_ref_a;
		logic [11:0] sample_ref_b;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  detector_state;
		logic        window_full;
		logic [31:0] power_main;
		logic [31:0] power_ref_a;
		logic [31:0] power_ref_b;
		logic [31:0] ratio_main_a;
		logic [31:0] ratio_main_b;
		logic [8:0]  zcr_main_tenths;
		logic [8:0]  zcr_ref_a_tenths;
		logic [8:0]  zcr_ref_b_tenths;
		logic        criteria_pass;
	} out_item_t;

	typedef struct packed {
		logic       capture;
		logic       push;
		logic       clear;
		logic       acc_clr;
		logic       pass_filt;
		logic       rd_en;
		logic       div_start;
		logic [2:0] div_sel;
		logic [1:0] ch;
		logic       decide;
		logic       emit;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       full;
		logic       rd_last;
		logic       div_busy;
		logic       div_done;
		logic       out_busy;
	} stat_t;

endpackage

// ----- design/ifwd_div.sv -----
module ifwd_div #(
	parameter int DW = 50
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [31:0]   divisor,
	output logic          busy,
	output logic          done,
	output logic [DW-1:0] quotient
);
	localparam int STEPS = (DW + 1) / 2;
	localparam int CNTW  = $clog2(STEPS + 1);

	logic [32:0]   rem_q;
	logic [DW-1:0] quo_q;
	logic [31:0]   div_q;
	logic [CNTW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [32:0]   r;
	logic [DW-1:0] q;

	// two restoring steps per cycle
	always_comb begin
		r = rem_q;
		q = quo_q;
		for (int k = 0; k < 2; k++) begin
			r = {r[31:0], q[DW-1]};
			q = {q[DW-2:0], 1'b0};
			if (r >= {1'b0, div_q}) begin
				r = r - {1'b0, div_q};
				q[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= r;
			quo_q <= q;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- design/ifwd_dp.sv -----
module ifwd_dp #(
	parameter int WINDOW      = 50,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ifwd_pkg::in_item_t  in_data,
	input  ifwd_pkg::cmd_t      cmd,
	output ifwd_pkg::stat_t     stat,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_wdata,
	input  logic                out_ready,
	output logic                out_valid,
	output ifwd_pkg::out_item_t out_data
);
	import ifwd_pkg::*;

	localparam int SB   = SAMPLE_BITS;
	localparam int PW   = $clog2(WINDOW);
	localparam int SUMW = SB + 8;
	localparam int YW   = SB + 4;
	localparam int AW   = YW + 17;
	localparam int SQW  = 2 * YW + 8;
	localparam int DW   = SQW + 10;
	localparam int EW   = 3 * SB;

	localparam logic [PW:0] WIN = (PW + 1)'(WINDOW);
	localparam logic signed [AW-1:0] K_B0 = AW'(COEF_B0);
	localparam logic signed [AW-1:0] K_B1 = AW'(COEF_B1);
	localparam logic signed [AW-1:0] K_A1 = AW'(COEF_A1);
	localparam logic signed [AW-1:0] K_A2 = AW'(COEF_A2);

	function automatic logic [DW-1:0] times_1000(input logic [DW-1:0] a);
		return (a << 10) - (a << 4) - (a << 3);
	endfunction

	function automatic logic [31:0] sat32(input logic [DW-1:0] a);
		return (a[DW-1:32] != '0) ? 32'hffff_ffff : a[31:0];
	endfunction

	in_item_t item_q;
	logic [EW-1:0] mem [WINDOW];
	logic [PW-1:0] wp_q;
	logic [PW:0]   fill_q;
	logic [PW-1:0] rd_cnt_q;
	logic [PW:0]   addr_sum;
	logic [PW-1:0] rd_addr;
	logic [EW-1:0] rd_data_s1;
	logic          v_s1, v_s2, v_s3, v_s4;
	logic          filt_q;
	logic [15:0]   m16, a16, b16;
	logic [SB-1:0] samp_s1;
	logic [SUMW-1:0] sum_q;
	logic [SB-1:0] mean_q;
	logic signed [SB:0] x0, x1_q, x2_q;
	logic signed [AW-1:0] ff_s2, acc;
	logic signed [YW-1:0] y1_q, y2_q, y_s3, ynew;
	logic signed [2*YW-1:0] prod;
	logic [2*YW-1:0] sq_s4;
	logic [SQW-1:0]  sq_acc_q;
	logic [PW-1:0]   cross_q;
	logic            first_q;

	logic [31:0]   power_q [3];
	logic [PW-1:0] cross_st_q [3];
	logic [8:0]    tenths_q [3];
	logic [31:0]   ratio_a_q, ratio_b_q;
	logic [1:0]    alarm_q;
	logic [31:0]   wst_q;
	logic          pass_q;

	logic [31:0] thr_power_q, thr_ra_q, thr_rb_q, confirm_q;
	logic [15:0] freq_low_q, freq_high_q;

	logic          div_busy, div_done;
	logic [DW-1:0] dividend, quotient;
	logic [31:0]   divisor;

	logic [PW-1:0] d1, d2;
	logic [PW+3:0] d1x10, d2x10;
	logic          pass;

	out_item_t out_q;
	logic      out_valid_q;

	// item capture and configuration
	always_ff @(posedge clk) begin
		if (cmd.capture)
			item_q <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_power_q <= '0;
			thr_ra_q    <= '0;
			thr_rb_q    <= '0;
			freq_low_q  <= '0;
			freq_high_q <= FREQ_HIGH_RST;
			confirm_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POWER_THR:   thr_power_q <= cfg_wdata;
				REG_RATIO_A_THR: thr_ra_q    <= cfg_wdata;
				REG_RATIO_B_THR: thr_rb_q    <= cfg_wdata;
				REG_FREQ_LOW:    freq_low_q  <= cfg_wdata[15:0];
				REG_FREQ_HIGH:   freq_high_q <= cfg_wdata[15:0];
				REG_CONFIRM:     confirm_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// window ring
	assign m16 = {4'b0, item_q.sample_main};
	assign a16 = {4'b0, item_q.sample_ref_a};
	assign b16 = {4'b0, item_q.sample_ref_b};

	assign addr_sum = {1'b0, wp_q} + {1'b0, rd_cnt_q};
	assign rd_addr  = (addr_sum >= WIN) ? PW'(addr_sum - WIN) : addr_sum[PW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.push)
			mem[wp_q] <= {b16[SB-1:0], a16[SB-1:0], m16[SB-1:0]};
		if (cmd.rd_en)
			rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (cmd.clear) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (cmd.push) begin
			wp_q <= (wp_q == PW'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
			if (fill_q < WIN)
				fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			filt_q   <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1 & filt_q;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (cmd.acc_clr) begin
				rd_cnt_q <= '0;
				filt_q   <= cmd.pass_filt;
			end else if (cmd.rd_en) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		case (cmd.ch)
			2'd1:    samp_s1 = rd_data_s1[2*SB-1:SB];
			2'd2:    samp_s1 = rd_data_s1[3*SB-1:2*SB];
			default: samp_s1 = rd_data_s1[SB-1:0];
		endcase
	end

	// filter pipeline
	assign x0   = $signed({1'b0, samp_s1}) - $signed({1'b0, mean_q});
	assign acc  = ff_s2 + K_A1 * AW'(y1_q) - K_A2 * AW'(y2_q);
	assign ynew = YW'(acc >>> 15);
	assign prod = y_s3 * y_s3;

	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			sum_q    <= '0;
			sq_acc_q <= '0;
			x1_q     <= '0;
			x2_q     <= '0;
			y1_q     <= '0;
			y2_q     <= '0;
			cross_q  <= '0;
			first_q  <= 1'b1;
		end else begin
			if (v_s1 && !filt_q)
				sum_q <= sum_q + SUMW'(samp_s1);
			if (v_s1 && filt_q) begin
				ff_s2 <= K_B0 * (AW'(x0) + AW'(x2_q)) + K_B1 * AW'(x1_q);
				x2_q  <= x1_q;
				x1_q  <= x0;
			end
			if (v_s2) begin
				y_s3 <= ynew;
				y2_q <= y1_q;
				y1_q <= ynew;
				first_q <= 1'b0;
				if (!first_q && (ynew[YW-1] != y1_q[YW-1]))
					cross_q <= cross_q + 1'b1;
			end
			if (v_s3)
				sq_s4 <= prod;
			if (v_s4)
				sq_acc_q <= sq_acc_q + SQW'(sq_s4);
		end
	end

	// shared divider
	always_comb begin
		dividend = '0;
		divisor  = '0;
		case (cmd.div_sel)
			DS_MEAN: begin
				dividend = DW'(sum_q);
				divisor  = 32'(WINDOW);
			end
			DS_POWER: begin
				dividend = times_1000(DW'(sq_acc_q));
				divisor  = 32'(WINDOW);
			end
			DS_RATIO_A: begin
				dividend = times_1000(DW'(power_q[0]));
				divisor  = power_q[1];
			end
			DS_RATIO_B: begin
				dividend = times_1000(DW'(power_q[0]));
				divisor  = power_q[2];
			end
			DS_TENTHS: begin
				dividend = times_1000(DW'(cross_st_q[cmd.ch])) + DW'(WINDOW);
				divisor  = 32'(2 * WINDOW);
			end
			default: ;
		endcase
	end

	ifwd_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		if (div_done && cmd.div_sel == DS_MEAN)
			mean_q <= quotient[SB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				power_q[i]    <= '0;
				cross_st_q[i] <= '0;
				tenths_q[i]   <= '0;
			end
			ratio_a_q <= RATIO_ZERO_DEN;
			ratio_b_q <= RATIO_ZERO_DEN;
		end else if (div_done) begin
			case (cmd.div_sel)
				DS_POWER: begin
					power_q[cmd.ch]    <= sat32(quotient);
					cross_st_q[cmd.ch] <= cross_q;
				end
				DS_RATIO_A:
					ratio_a_q <= (power_q[1] == '0) ? RATIO_ZERO_DEN : sat32(quotient);
				DS_RATIO_B:
					ratio_b_q <= (power_q[2] == '0) ? RATIO_ZERO_DEN : sat32(quotient);
				DS_TENTHS:
					tenths_q[cmd.ch] <= quotient[8:0];
				default: ;
			endcase
		end
	end

	// flame criteria
	assign d1 = (cross_st_q[0] > cross_st_q[1]) ? cross_st_q[0] - cross_st_q[1]
		: cross_st_q[1] - cross_st_q[0];
	assign d2 = (cross_st_q[0] > cross_st_q[2]) ? cross_st_q[0] - cross_st_q[2]
		: cross_st_q[2] - cross_st_q[0];
	assign d1x10 = (PW + 4)'({d1, 3'b0}) + (PW + 4)'({d1, 1'b0});
	assign d2x10 = (PW + 4)'({d2, 3'b0}) + (PW + 4)'({d2, 1'b0});

	assign pass = (power_q[0] >= thr_power_q)
		&& (ratio_a_q >= thr_ra_q)
		&& (ratio_b_q >= thr_rb_q)
		&& ({7'b0, tenths_q[0]} >= freq_low_q)
		&& ({7'b0, tenths_q[0]} <= freq_high_q)
		&& (d1x10 <= (PW + 4)'(WINDOW))
		&& (d2x10 <= (PW + 4)'(WINDOW));

	// detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_q <= AL_IDLE;
			wst_q   <= '0;
			pass_q  <= 1'b0;
		end else if (cmd.capture) begin
			pass_q <= 1'b0;
		end else if (cmd.clear) begin
			alarm_q <= AL_IDLE;
			wst_q   <= '0;
		end else if (cmd.decide) begin
			pass_q <= pass;
			case (alarm_q)
				AL_IDLE: begin
					if (pass) begin
						alarm_q <= AL_WARN;
						wst_q   <= item_q.now_ms;
					end
				end
				AL_WARN: begin
					if (!pass)
						alarm_q <= AL_IDLE;
					else if ((item_q.now_ms - wst_q) >= confirm_q)
						alarm_q <= AL_FIRE;
				end
				AL_FIRE: ;
				default: alarm_q <= AL_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.detector_state   <= alarm_q;
			out_q.window_full      <= (fill_q == WIN);
			out_q.power_main       <= power_q[0];
			out_q.power_ref_a      <= power_q[1];
			out_q.power_ref_b      <= power_q[2];
			out_q.ratio_main_a     <= ratio_a_q;
			out_q.ratio_main_b     <= ratio_b_q;
			out_q.zcr_main_tenths  <= tenths_q[0];
			out_q.zcr_ref_a_tenths <= tenths_q[1];
			out_q.zcr_ref_b_tenths <= tenths_q[2];
			out_q.criteria_pass    <= pass_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign stat.op       = item_q.op;
	assign stat.full     = (fill_q == WIN);
	assign stat.rd_last  = (rd_cnt_q == PW'(WINDOW - 1));
	assign stat.div_busy = div_busy;
	assign stat.div_done = div_done;
	assign stat.out_busy = out_valid_q && !out_ready;

endmodule

// ----- design/ifwd_ctrl.sv -----
module ifwd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ifwd_pkg::stat_t stat,
	output ifwd_pkg::cmd_t  cmd
);
	import ifwd_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CMD   = 4'd1;
	localparam logic [3:0] S_CHK   = 4'd2;
	localparam logic [3:0] S_SUM0  = 4'd3;
	localparam logic [3:0] S_SUM   = 4'd4;
	localparam logic [3:0] S_FILT0 = 4'd5;
	localparam logic [3:0] S_FILT  = 4'd6;
	localparam logic [3:0] S_DRAIN = 4'd7;
	localparam logic [3:0] S_DIVGO = 4'd8;
	localparam logic [3:0] S_DIVW  = 4'd9;
	localparam logic [3:0] S_NEXT  = 4'd10;
	localparam logic [3:0] S_DEC   = 4'd11;
	localparam logic [3:0] S_EMIT  = 4'd12;

	localparam logic [2:0] DRAIN_LAST = 3'd4;

	logic [3:0] state_q, state_d;
	logic [1:0] ch_q, ch_d;
	logic [2:0] sel_q, sel_d;
	logic [2:0] drain_q, drain_d;

	always_comb begin
		state_d = state_q;
		ch_d    = ch_q;
		sel_d   = sel_q;
		drain_d = drain_q;
		cmd     = '0;
		cmd.ch      = ch_q;
		cmd.div_sel = sel_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CMD;
				end
			end
			S_CMD: begin
				case (stat.op)
					OP_RESET: begin
						cmd.clear = 1'b1;
						state_d   = S_EMIT;
					end
					OP_PUSH: begin
						cmd.push = 1'b1;
						state_d  = S_CHK;
					end
					OP_EVAL: state_d = S_CHK;
					default: state_d = S_EMIT;
				endcase
			end
			S_CHK: begin
				ch_d    = 2'd0;
				state_d = stat.full ? S_SUM0 : S_EMIT;
			end
			S_SUM0: begin
				cmd.acc_clr = 1'b1;
				sel_d       = DS_MEAN;
				state_d     = S_SUM;
			end
			S_SUM, S_FILT: begin
				cmd.rd_en = 1'b1;
				if (stat.rd_last) begin
					drain_d = '0;
					state_d = S_DRAIN;
				end
			end
			S_FILT0: begin
				cmd.acc_clr   = 1'b1;
				cmd.pass_filt = 1'b1;
				sel_d         = DS_POWER;
				state_d       = S_FILT;
			end
			S_DRAIN: begin
				drain_d = drain_q + 1'b1;
				if (drain_q == DRAIN_LAST)
					state_d = S_DIVGO;
			end
			S_DIVGO: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIVW;
			end
			S_DIVW: begin
				if (stat.div_done)
					state_d = S_NEXT;
			end
			S_NEXT: begin
				case (sel_q)
					DS_MEAN: state_d = S_FILT0;
					DS_POWER: begin
						if (ch_q != CH_LAST) begin
							ch_d    = ch_q + 1'b1;
							state_d = S_SUM0;
						end else begin
							sel_d   = DS_RATIO_A;
							state_d = S_DIVGO;
						end
					end
					DS_RATIO_A: begin
						sel_d   = DS_RATIO_B;
						state_d = S_DIVGO;
					end
					DS_RATIO_B: begin
						sel_d   = DS_TENTHS;
						ch_d    = 2'd0;
						state_d = S_DIVGO;
					end
					DS_TENTHS: begin
						if (ch_q != CH_LAST) begin
							ch_d    = ch_q + 1'b1;
							state_d = S_DIVGO;
						end else begin
							state_d = S_DEC;
						end
					end
					default: state_d = S_DEC;
				endcase
			end
			S_DEC: begin
				cmd.decide = 1'b1;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				if (!stat.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ch_q    <= '0;
			sel_q   <= DS_MEAN;
			drain_q <= '0;
		end else begin
			state_q <= state_d;
			ch_q    <= ch_d;
			sel_q   <= sel_d;
			drain_q <= drain_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

`ifndef NO_ASSERTIONS
	a_div_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !stat.div_busy)
		else $error("divider started while busy");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !stat.out_busy)
		else $error("result overwritten before transfer");
	a_read_no_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !stat.div_busy)
		else $error("window pass overlaps a division");
	a_accept_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_CMD))
		else $error("accepted item not decoded");
`endif

endmodule

// ----- design/ir_flame_window_detector.sv -----
// ir flame window detector: three ir channels (main, reference a, reference b) are
// pushed into a shared window ring; once the ring is full each item runs every channel
// through floor-mean removal, a q15 low-pass biquad started from zero, a mean-square
// power x1000 and a zero-crossing count, then forms two power ratios x1000 (9999 on a
// zero divisor), tests five flame criteria and steps an idle/warning/fire machine with
// a confirm time. fire holds until a reset op. one item is handled at a time; an item
// is also held while the previous result still waits for its transfer. two passes over
// the window per channel through the single ring read port and the eleven divisions on
// the one shared radix-4 divider set how long an evaluating item takes. the result sits
// in an output register, so the next item is taken as soon as the result has been
// handed over or is waiting alone. configuration writes take effect at once and are
// meant for idle periods only.
module ir_flame_window_detector #(
	parameter int WINDOW      = ifwd_pkg::WINDOW_DEF,
	parameter int SAMPLE_BITS = ifwd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// item input
	input  logic                in_valid,
	output logic                in_ready,
	input  ifwd_pkg::in_item_t  in_data,
	// result output
	output logic                out_valid,
	input  logic                out_ready,
	output ifwd_pkg::out_item_t out_data,
	// configuration writes
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_wdata
);
	import ifwd_pkg::*;

	// sequencing commands and returned status
	cmd_t  cmd;
	stat_t stat;

	// controller: walks op decode, window passes, divisions and the decision
	ifwd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: ring, filter pipeline, divider, feature store, result register
	ifwd_dp #(
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

// ----- dv/tb.sv -----
module tb;
	import ifwd_pkg::*;

	localparam int WIN        = WINDOW_DEF;
	localparam int NCH        = 3;
	localparam int WDOG_LIMIT = 20000;
	localparam logic [31:0] SAT32 = 32'hffff_ffff;
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam logic [1:0] OP_NONE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_wdata = '0;

	ir_flame_window_detector dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// items waiting to be offered, and results owed by the block
	in_item_t pending_items[$];
	out_item_t owed_results[$];

	int send_idle_pct = 31;
	int recv_idle_pct = 88;
	int errors = 0;
	int quiet_cycles = 0;

	// shadow of the detector: settings
	logic [31:0] thr_power, thr_ratio_a, thr_ratio_b, thr_confirm;
	logic [15:0] freq_lo, freq_hi;

	// shadow of the detector: ring and features
	logic [11:0] ring[NCH][WIN];
	int unsigned ring_wp, ring_fill;
	logic [1:0] alarm;
	logic [31:0] warn_start;
	logic [31:0] chan_pow[NCH];
	int unsigned chan_cross[NCH];

	// stimulus generator state
	logic [31:0] clock_ms;

	function automatic longint q15_floor(longint acc);
		if (acc >= 0)
			return acc / 32768;
		return -((-acc + 32767) / 32768);
	endfunction

	// mean removal, zero-state biquad, mean square and crossings of one channel
	function automatic void measure_channel(int ch);
		longint filt[WIN];
		longint unsigned total, sq;
		longint mean, x0, x1, x2, y0, y1, y2;
		int unsigned n_cross;
		total = 0; sq = 0; n_cross = 0;
		x1 = 0; x2 = 0; y1 = 0; y2 = 0;
		for (int i = 0; i < WIN; i++) begin
			filt[i] = longint'(ring[ch][(ring_wp + i) % WIN]);
			total += filt[i];
		end
		mean = total / WIN;
		for (int i = 0; i < WIN; i++) begin
			x0 = filt[i] - mean;
			y0 = q15_floor(COEF_B0 * x0 + COEF_B1 * x1 + COEF_B0 * x2 + COEF_A1 * y1
				- COEF_A2 * y2);
			filt[i] = y0;
			x2 = x1; x1 = x0;
			y2 = y1; y1 = y0;
		end
		for (int i = 0; i < WIN; i++) begin
			sq += filt[i] * filt[i];
			if (i > 0 && ((filt[i-1] < 0) != (filt[i] < 0)))
				n_cross++;
		end
		sq = sq * 1000 / WIN;
		chan_pow[ch] = (sq > SAT32) ? SAT32 : sq[31:0];
		chan_cross[ch] = n_cross;
	endfunction

	function automatic logic [31:0] power_ratio(logic [31:0] num, logic [31:0] den);
		longint unsigned r;
		if (den == 0)
			return RATIO_ZERO_DEN;
		r = longint'(num) * 1000 / den;
		return (r > SAT32) ? SAT32 : r[31:0];
	endfunction

	function automatic int unsigned rate_tenths(int unsigned c);
		return (c * 1000 + WIN) / (2 * WIN);
	endfunction

	function automatic bit rates_close(int unsigned a, int unsigned b);
		int unsigned d;
		d = (a > b) ? a - b : b - a;
		return d * 10 <= WIN;
	endfunction

	function automatic bit flame_criteria();
		int unsigned z;
		z = rate_tenths(chan_cross[0]);
		return chan_pow[0] >= thr_power
			&& power_ratio(chan_pow[0], chan_pow[1]) >= thr_ratio_a
			&& power_ratio(chan_pow[0], chan_pow[2]) >= thr_ratio_b
			&& z >= freq_lo && z <= freq_hi
			&& rates_close(chan_cross[0], chan_cross[1])
			&& rates_close(chan_cross[0], chan_cross[2]);
	endfunction

	// advance the shadow by one item and return the result it owes
	function automatic out_item_t detector_step(in_item_t it);
		out_item_t r;
		bit ok;
		ok = 1'b0;
		if (it.op == OP_RESET) begin
			alarm = AL_IDLE;
			warn_start = '0;
			ring_wp = 0;
			ring_fill = 0;
		end else if (it.op == OP_PUSH || it.op == OP_EVAL) begin
			if (it.op == OP_PUSH) begin
				ring[0][ring_wp] = it.sample_main;
				ring[1][ring_wp] = it.sample_ref_a;
				ring[2][ring_wp] = it.sample_ref_b;
				ring_wp = (ring_wp + 1) % WIN;
				if (ring_fill < WIN)
					ring_fill++;
			end
			if (ring_fill >= WIN) begin
				for (int ch = 0; ch < NCH; ch++)
					measure_channel(ch);
				ok = flame_criteria();
				case (alarm)
					AL_IDLE: begin
						if (ok) begin
							alarm = AL_WARN;
							warn_start = it.now_ms;
						end
					end
					AL_WARN: begin
						if (!ok)
							alarm = AL_IDLE;
						else if (it.now_ms - warn_start >= thr_confirm)
							alarm = AL_FIRE;
					end
					AL_FIRE: ;
					default: alarm = AL_IDLE;
				endcase
			end
		end
		r.detector_state   = alarm;
		r.window_full      = ring_fill >= WIN;
		r.power_main       = chan_pow[0];
		r.power_ref_a      = chan_pow[1];
		r.power_ref_b      = chan_pow[2];
		r.ratio_main_a     = power_ratio(chan_pow[0], chan_pow[1]);
		r.ratio_main_b     = power_ratio(chan_pow[0], chan_pow[2]);
		r.zcr_main_tenths  = 9'(rate_tenths(chan_cross[0]));
		r.zcr_ref_a_tenths = 9'(rate_tenths(chan_cross[1]));
		r.zcr_ref_b_tenths = 9'(rate_tenths(chan_cross[2]));
		r.criteria_pass    = ok;
		return r;
	endfunction

	// driver: offers queued items, predicts each one on its transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				owed_results.push_back(detector_step(in_data));
			if (!in_valid || in_ready) begin
				if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= pending_items.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random back-pressure and field-by-field comparison
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (owed_results.size() == 0) begin
					errors++;
					$display("%0t: result with nothing owed: %p", $time, out_data);
				end else begin
					want = owed_results.pop_front();
					if (want.detector_state !== out_data.detector_state ||
					    want.window_full !== out_data.window_full ||
					    want.power_main !== out_data.power_main ||
					    want.power_ref_a !== out_data.power_ref_a ||
					    want.power_ref_b !== out_data.power_ref_b ||
					    want.ratio_main_a !== out_data.ratio_main_a ||
					    want.ratio_main_b !== out_data.ratio_main_b ||
					    want.zcr_main_tenths !== out_data.zcr_main_tenths ||
					    want.zcr_ref_a_tenths !== out_data.zcr_ref_a_tenths ||
					    want.zcr_ref_b_tenths !== out_data.zcr_ref_b_tenths ||
					    want.criteria_pass !== out_data.criteria_pass) begin
						errors++;
						$display("%0t: mismatch\n  expected %p\n  actual   %p",
							$time, want, out_data);
					end
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// watchdog: cycles with no transfer on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// register writes go to the block first and to the shadow once the last write is done
	task automatic write_settings(logic [31:0] p, logic [31:0] ra, logic [31:0] rb,
		logic [15:0] lo, logic [15:0] hi, logic [31:0] conf);
		logic [31:0] vals[6];
		vals = '{p, ra, rb, {16'd0, lo}, {16'd0, hi}, conf};
		for (int i = 0; i < 6; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= i[2:0];
			cfg_wdata <= vals[i];
		end
		// unknown index, must be ignored
		@(posedge clk);
		cfg_index <= REG_UNUSED;
		cfg_wdata <= $urandom();
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_power = p; thr_ratio_a = ra; thr_ratio_b = rb;
		freq_lo = lo; freq_hi = hi; thr_confirm = conf;
	endtask

	task automatic random_settings();
		write_settings($urandom_range(0, 50_000_000), $urandom_range(0, 3000),
			$urandom_range(0, 3000), 16'($urandom_range(0, 120)),
			16'($urandom_range(150, 490)), $urandom_range(0, 300));
	endtask

	task automatic queue_item(logic [1:0] op, logic [11:0] m, logic [11:0] a,
		logic [11:0] b);
		in_item_t it;
		it.op = op;
		it.sample_main = m;
		it.sample_ref_a = a;
		it.sample_ref_b = b;
		it.now_ms = clock_ms;
		clock_ms += 10;
		pending_items.push_back(it);
	endtask

	function automatic logic [11:0] wave_point(int base, int amp, int period, int k);
		int t, tri_v, v;
		t = k % period;
		tri_v = (t < period / 2) ? t : period - t;
		v = base + (amp * (4 * tri_v - period)) / period + int'($urandom_range(0, 3));
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		return v[11:0];
	endfunction

	// mostly in-phase triangle waves on the three channels, some noise items
	task automatic build_phase(int n_items);
		int made, run_len, period, base, amp_m, amp_a, amp_b;
		made = 0;
		while (made < n_items) begin
			if ($urandom_range(0, 99) < 8) begin
				queue_item(2'($urandom_range(0, 3)), 12'($urandom()), 12'($urandom()),
					12'($urandom()));
				clock_ms = $urandom_range(0, 3) == 0 ? $urandom() : clock_ms;
				made++;
			end else begin
				if ($urandom_range(0, 3) == 0) begin
					queue_item(OP_RESET, 12'($urandom()), 12'($urandom()),
						12'($urandom()));
					made++;
				end
				run_len = $urandom_range(55, 130);
				period = $urandom_range(4, 40);
				base = $urandom_range(0, 4095);
				amp_m = $urandom_range(0, 2500);
				amp_a = $urandom_range(0, amp_m);
				amp_b = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, amp_m);
				for (int k = 0; k < run_len; k++) begin
					if ($urandom_range(0, 19) == 0)
						queue_item(OP_EVAL, 12'($urandom()), 12'($urandom()),
							12'($urandom()));
					else
						queue_item(OP_PUSH, wave_point(base, amp_m, period, k),
							wave_point(base, amp_a, period, k),
							wave_point(base, amp_b, period, k));
				end
				made += run_len;
			end
		end
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || in_valid || owed_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		thr_power = '0; thr_ratio_a = '0; thr_ratio_b = '0;
		freq_lo = '0; freq_hi = FREQ_HIGH_RST; thr_confirm = '0;
		ring_wp = 0; ring_fill = 0; alarm = AL_IDLE; warn_start = '0;
		for (int ch = 0; ch < NCH; ch++) begin
			chan_pow[ch] = '0;
			chan_cross[ch] = 0;
			for (int i = 0; i < WIN; i++)
				ring[ch][i] = '0;
		end
		clock_ms = 32'hffff_ff00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset values, evaluation on an empty ring, unused op, reset op,
		// extreme samples and a wrapping timestamp
		write_settings('0, '0, '0, '0, FREQ_HIGH_RST, '0);
		queue_item(OP_EVAL, 12'hfff, 12'hfff, 12'hfff);
		queue_item(OP_NONE, 12'h000, 12'hfff, 12'h000);
		queue_item(OP_RESET, 12'hfff, 12'h000, 12'hfff);
		for (int k = 0; k < 20; k++)
			queue_item(OP_PUSH, k[0] ? 12'hfff : 12'h000, k[1] ? 12'hfff : 12'h000,
				k[2] ? 12'hfff : 12'h000);
		drain();

		// sender idles less than not, receiver mostly stalls
		send_idle_pct = 31; recv_idle_pct = 88;
		random_settings();
		build_phase(340);
		drain();

		// then the other way round, with an endless confirm time
		send_idle_pct = 88; recv_idle_pct = 31;
		write_settings('0, '0, '0, '0, FREQ_HIGH_RST, SAT32);
		build_phase(340);
		drain();

		// no idling: all settings at their maximum, then ordinary ones
		send_idle_pct = 0; recv_idle_pct = 0;
		write_settings(SAT32, SAT32, SAT32, 16'hffff, 16'hffff, SAT32);
		build_phase(60);
		drain();
		random_settings();
		build_phase(300);
		drain();

		repeat (700) @(posedge clk);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
